### hw/rtl/s5h_pkg.sv
`default_nettype none

package s5h_pkg;

   // protocol bytes
   localparam logic [7:0] SOCKS_VER   = 8'h05;
   localparam logic [7:0] CMD_CONNECT = 8'h01;
   localparam logic [7:0] ATYP_IPV4   = 8'h01;
   localparam logic [7:0] ATYP_DOMAIN = 8'h03;
   localparam logic [7:0] ATYP_IPV6   = 8'h04;
   localparam logic [7:0] AUTH_NONE   = 8'h00;
   localparam logic [7:0] AUTH_REJECT = 8'hFF;
   localparam logic [7:0] REP_OK      = 8'h00;
   localparam logic [7:0] REP_FAIL    = 8'h01;
   localparam logic [7:0] REP_CMD_BAD = 8'h07;

   // address type codes on the result channel
   localparam logic [1:0] AT_IPV4   = 2'd0;
   localparam logic [1:0] AT_DOMAIN = 2'd1;
   localparam logic [1:0] AT_IPV6   = 2'd2;

   localparam logic [7:0] IPV4_LEN = 8'd4;
   localparam logic [7:0] IPV6_LEN = 8'd16;

   // full reply is version, code, rsv, atyp, 4 addr bytes, 2 port bytes minus
   // one: 05 cc 00 00 00 00 00 00 00
   localparam int REPLY_LEN = 9;
   localparam int IDX_W     = $clog2(REPLY_LEN + 1);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [3:0] {
      PH_VER,
      PH_NMETH,
      PH_NMETH_BAD,
      PH_METHODS,
      PH_RVER,
      PH_CMD,
      PH_RSV,
      PH_ATYP,
      PH_DOMLEN,
      PH_ADDR,
      PH_PORT_HI,
      PH_PORT_LO,
      PH_WAIT,
      PH_RELAY,
      PH_CLOSED
   } phase_type;

   typedef enum logic [2:0] {
      KIND_REPLY,
      KIND_ADDR,
      KIND_OPEN,
      KIND_CLOSE,
      KIND_RELAY
   } kind_type;

   // what the back end has to emit for one queued job
   typedef enum logic [2:0] {
      OP_ITEM,          // one result, fields taken from the job
      OP_AUTH_OK,       // 05 00
      OP_AUTH_BAD,      // 05 FF, close
      OP_REPLY,         // 9-byte reply, code in data
      OP_REPLY_CLOSE    // 9-byte reply, then close
   } op_type;

   typedef struct packed {
      op_type      op;
      kind_type    kind;
      logic [7:0]  data;
      logic [1:0]  addr_type;
      logic [15:0] port;
   } job_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
      logic [1:0]  addr_type;
      logic [15:0] port;
      logic        last;
   } beat_type;

   // result number idx of a job
   function automatic beat_type expand(input job_type j, input logic [IDX_W-1:0] idx);
      beat_type b;
      b = '0;
      b.kind = KIND_REPLY;
      unique case (j.op)
         OP_ITEM: begin
            b.kind      = j.kind;
            b.data      = j.data;
            b.addr_type = j.addr_type;
            b.port      = j.port;
            b.last      = 1'b1;
         end
         OP_AUTH_OK: begin
            b.data = (idx == '0) ? SOCKS_VER : AUTH_NONE;
            b.last = (idx == IDX_W'(1));
         end
         OP_AUTH_BAD: begin
            if (idx == IDX_W'(2)) begin
               b.kind = KIND_CLOSE;
               b.last = 1'b1;
            end else begin
               b.data = (idx == '0) ? SOCKS_VER : AUTH_REJECT;
            end
         end
         OP_REPLY, OP_REPLY_CLOSE: begin
            if (j.op == OP_REPLY_CLOSE && idx == IDX_W'(REPLY_LEN)) begin
               b.kind = KIND_CLOSE;
               b.last = 1'b1;
            end else begin
               b.data = (idx == '0) ? SOCKS_VER :
                        (idx == IDX_W'(1)) ? j.data : 8'h00;
               b.last = (j.op == OP_REPLY) && (idx == IDX_W'(REPLY_LEN - 1));
            end
         end
         default: begin
            b.last = 1'b1;
         end
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/s5h_if.sv
`default_nettype none

interface s5h_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] in_byte;
   logic       open_ok;

   modport source (output valid, output mode, output in_byte, output open_ok, input ready);
   modport sink   (input valid, input mode, input in_byte, input open_ok, output ready);
endinterface

interface s5h_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [7:0]  data;
   logic [1:0]  addr_type;
   logic [15:0] target_port;
   logic        last;

   modport source (output valid, output kind, output data, output addr_type,
                   output target_port, output last, input ready);
   modport sink   (input valid, input kind, input data, input addr_type,
                   input target_port, input last, output ready);
endinterface

`default_nettype wire

### hw/rtl/s5h_front.sv
`default_nettype none

module s5h_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write_enable,
   input  wire logic              csr_write_data,
   s5h_req_if.sink                req,
   input  wire logic              queue_full,
   output logic                   push,
   output s5h_pkg::job_type       job
);

   logic                  socks_enable_ff;
   s5h_pkg::phase_type    phase_ff, phase_in;
   logic [7:0]            bytes_left_ff, bytes_left_in;
   logic [7:0]            command_ff, command_in;
   logic [1:0]            address_kind_ff, address_kind_in;
   logic                  domain_empty_ff, domain_empty_in;
   logic [15:0]           port_ff, port_in;
   logic                  fire;

   assign req.ready = !queue_full;
   assign fire      = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         socks_enable_ff <= 1'b1;
      end else if (csr_write_enable) begin
         socks_enable_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= s5h_pkg::PH_VER;
         bytes_left_ff   <= '0;
         command_ff      <= '0;
         address_kind_ff <= '0;
         domain_empty_ff <= 1'b0;
         port_ff         <= '0;
      end else begin
         phase_ff        <= phase_in;
         bytes_left_ff   <= bytes_left_in;
         command_ff      <= command_in;
         address_kind_ff <= address_kind_in;
         domain_empty_ff <= domain_empty_in;
         port_ff         <= port_in;
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      bytes_left_in   = bytes_left_ff;
      command_in      = command_ff;
      address_kind_in = address_kind_ff;
      domain_empty_in = domain_empty_ff;
      port_in         = port_ff;
      push            = 1'b0;
      job             = '0;
      job.op          = s5h_pkg::OP_ITEM;
      job.kind        = s5h_pkg::KIND_REPLY;

      if (fire) begin
         if (!socks_enable_ff) begin
            // bypass: relay every byte, parser state untouched
            if (!req.mode) begin
               push     = 1'b1;
               job.kind = s5h_pkg::KIND_RELAY;
               job.data = req.in_byte;
            end
         end else if (!req.mode) begin
            unique case (phase_ff)
               s5h_pkg::PH_VER: begin
                  phase_in = (req.in_byte == s5h_pkg::SOCKS_VER) ?
                             s5h_pkg::PH_NMETH : s5h_pkg::PH_NMETH_BAD;
               end
               s5h_pkg::PH_NMETH_BAD: begin
                  push     = 1'b1;
                  job.op   = s5h_pkg::OP_AUTH_BAD;
                  phase_in = s5h_pkg::PH_CLOSED;
               end
               s5h_pkg::PH_NMETH: begin
                  if (req.in_byte == 8'h00) begin
                     push     = 1'b1;
                     job.op   = s5h_pkg::OP_AUTH_OK;
                     phase_in = s5h_pkg::PH_RVER;
                  end else begin
                     bytes_left_in = req.in_byte;
                     phase_in      = s5h_pkg::PH_METHODS;
                  end
               end
               s5h_pkg::PH_METHODS: begin
                  bytes_left_in = bytes_left_ff - 8'd1;
                  if (bytes_left_in == 8'h00) begin
                     push     = 1'b1;
                     job.op   = s5h_pkg::OP_AUTH_OK;
                     phase_in = s5h_pkg::PH_RVER;
                  end
               end
               s5h_pkg::PH_RVER: begin
                  phase_in = s5h_pkg::PH_CMD;
               end
               s5h_pkg::PH_CMD: begin
                  command_in = req.in_byte;
                  phase_in   = s5h_pkg::PH_RSV;
               end
               s5h_pkg::PH_RSV: begin
                  phase_in = s5h_pkg::PH_ATYP;
               end
               s5h_pkg::PH_ATYP: begin
                  if (req.in_byte == s5h_pkg::ATYP_IPV4) begin
                     address_kind_in = s5h_pkg::AT_IPV4;
                     bytes_left_in   = s5h_pkg::IPV4_LEN;
                     domain_empty_in = 1'b0;
                     phase_in        = s5h_pkg::PH_ADDR;
                  end else if (req.in_byte == s5h_pkg::ATYP_DOMAIN) begin
                     address_kind_in = s5h_pkg::AT_DOMAIN;
                     phase_in        = s5h_pkg::PH_DOMLEN;
                  end else if (req.in_byte == s5h_pkg::ATYP_IPV6) begin
                     address_kind_in = s5h_pkg::AT_IPV6;
                     bytes_left_in   = s5h_pkg::IPV6_LEN;
                     domain_empty_in = 1'b0;
                     phase_in        = s5h_pkg::PH_ADDR;
                  end else begin
                     push     = 1'b1;
                     job.kind = s5h_pkg::KIND_CLOSE;
                     phase_in = s5h_pkg::PH_CLOSED;
                  end
               end
               s5h_pkg::PH_DOMLEN: begin
                  bytes_left_in   = req.in_byte;
                  domain_empty_in = (req.in_byte == 8'h00);
                  phase_in        = (req.in_byte == 8'h00) ?
                                    s5h_pkg::PH_PORT_HI : s5h_pkg::PH_ADDR;
               end
               s5h_pkg::PH_ADDR: begin
                  push          = 1'b1;
                  job.kind      = s5h_pkg::KIND_ADDR;
                  job.data      = req.in_byte;
                  job.addr_type = address_kind_ff;
                  bytes_left_in = bytes_left_ff - 8'd1;
                  if (bytes_left_in == 8'h00) begin
                     phase_in = s5h_pkg::PH_PORT_HI;
                  end
               end
               s5h_pkg::PH_PORT_HI: begin
                  port_in  = {req.in_byte, 8'h00};
                  phase_in = s5h_pkg::PH_PORT_LO;
               end
               s5h_pkg::PH_PORT_LO: begin
                  port_in = {port_ff[15:8], req.in_byte};
                  push    = 1'b1;
                  if (command_ff != s5h_pkg::CMD_CONNECT) begin
                     job.op   = s5h_pkg::OP_REPLY_CLOSE;
                     job.data = s5h_pkg::REP_CMD_BAD;
                     phase_in = s5h_pkg::PH_CLOSED;
                  end else if (port_in == 16'h0000 ||
                               (address_kind_ff == s5h_pkg::AT_DOMAIN && domain_empty_ff)) begin
                     job.kind = s5h_pkg::KIND_CLOSE;
                     phase_in = s5h_pkg::PH_CLOSED;
                  end else begin
                     job.kind      = s5h_pkg::KIND_OPEN;
                     job.addr_type = address_kind_ff;
                     job.port      = port_in;
                     phase_in      = s5h_pkg::PH_WAIT;
                  end
               end
               s5h_pkg::PH_RELAY: begin
                  push     = 1'b1;
                  job.kind = s5h_pkg::KIND_RELAY;
                  job.data = req.in_byte;
               end
               default: begin
                  // waiting for the open outcome, or closed: byte dropped
               end
            endcase
         end else if (phase_ff == s5h_pkg::PH_WAIT) begin
            push = 1'b1;
            if (req.open_ok) begin
               job.op   = s5h_pkg::OP_REPLY;
               job.data = s5h_pkg::REP_OK;
               phase_in = s5h_pkg::PH_RELAY;
            end else begin
               job.op   = s5h_pkg::OP_REPLY_CLOSE;
               job.data = s5h_pkg::REP_FAIL;
               phase_in = s5h_pkg::PH_CLOSED;
            end
         end
      end
   end

   a_closed_silent: assert property (@(posedge clock) disable iff (reset)
      (socks_enable_ff && phase_ff == s5h_pkg::PH_CLOSED) |-> !push)
      else $error("job issued after close");

   a_closed_sticks: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == s5h_pkg::PH_CLOSED) |=> (phase_ff == s5h_pkg::PH_CLOSED))
      else $error("left closed phase");

endmodule

`default_nettype wire

### hw/rtl/s5h_queue.sv
`default_nettype none

module s5h_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire s5h_pkg::job_type  push_job,
   output logic                   full,
   input  wire logic              pop,
   output s5h_pkg::job_type       head,
   output logic                   empty
);

   s5h_pkg::job_type                mem_ff [s5h_pkg::QUEUE_DEPTH];
   logic [s5h_pkg::QPTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [s5h_pkg::QCNT_W-1:0]      count_ff, count_in;

   assign full  = (count_ff == s5h_pkg::QCNT_W'(s5h_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + s5h_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - s5h_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + s5h_pkg::QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + s5h_pkg::QPTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");

endmodule

`default_nettype wire

### hw/rtl/s5h_back.sv
`default_nettype none

module s5h_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire s5h_pkg::job_type  head,
   input  wire logic              empty,
   output logic                   pop,
   s5h_rsp_if.source              rsp
);

   logic                           rsp_valid_ff, rsp_valid_in;
   s5h_pkg::beat_type              beat_ff, beat;
   logic [s5h_pkg::IDX_W-1:0]      idx_ff, idx_in;
   logic                           load;

   assign beat = s5h_pkg::expand(head, idx_ff);
   assign load = !empty && (!rsp_valid_ff || rsp.ready);
   assign pop  = load && beat.last;

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         idx_in       = beat.last ? '0 : idx_ff + s5h_pkg::IDX_W'(1);
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         beat_ff <= beat;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.kind        = beat_ff.kind;
   assign rsp.data        = beat_ff.data;
   assign rsp.addr_type   = beat_ff.addr_type;
   assign rsp.target_port = beat_ff.port;
   assign rsp.last        = beat_ff.last;

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= s5h_pkg::IDX_W'(s5h_pkg::REPLY_LEN))
      else $error("result index past longest job");

   a_idx_rewinds: assert property (@(posedge clock) disable iff (reset)
      pop |=> (idx_ff == '0))
      else $error("index not cleared after job");

endmodule

`default_nettype wire

### hw/rtl/socks5_connect_handshake.sv
`default_nettype none

// Server side of a SOCKS5 CONNECT handshake without authentication. Client
// bytes (mode 0) and the outcome of the channel open (mode 1, open_ok) enter
// on req_if, one item per cycle. Results leave on rsp_if: reply bytes, target
// address bytes as they arrive, one open request carrying address type and
// port, a close, or relayed bytes; last marks the final result of each input
// item. A front end runs the parser and turns each item into at most one job;
// a 4-entry job queue sits between it and a back end that expands each job
// into its results, one per cycle while the output is not stalled, into a
// registered output stage. An input item is taken every cycle while the
// queue has room; most items give zero or one result, the replies give 2,
// 3, 9 or 10 results. csr_write_enable / csr_write_data set the handshake
// enable (reset 1); with it at 0 every client byte is relayed and the parser
// state is frozen. After a close, input is dropped until reset while the
// enable is 1. Write the enable only while the block is idle.

module socks5_connect_handshake (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   csr_write_enable,
   input  wire logic   csr_write_data,
   s5h_req_if.sink     req_if,
   s5h_rsp_if.source   rsp_if
);

   logic              push;
   logic              pop;
   logic              full;
   logic              empty;
   s5h_pkg::job_type  push_job;
   s5h_pkg::job_type  head;

   // parser / classifier
   s5h_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req              (req_if),
      .queue_full       (full),
      .push             (push),
      .job              (push_job)
   );

   // decouples parser from result bursts
   s5h_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (full),
      .pop      (pop),
      .head     (head),
      .empty    (empty)
   );

   // job expansion and output register
   s5h_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .empty (empty),
      .pop   (pop),
      .rsp   (rsp_if)
   );

endmodule

`default_nettype wire

### tb/sv/s5h_result_check.sv
`timescale 1ns / 1ps

module s5h_result_check (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_write_enable,
   input  wire logic csr_write_data,
   s5h_req_if        req_mon,
   s5h_rsp_if        rsp_mon,
   output int        fail_count,
   output int        pending,
   output int        result_count
);
   import s5h_pkg::*;

   // session state as the block should hold it
   logic        hs_enable;
   phase_type   ph;
   logic [7:0]  left_count;
   logic [7:0]  cmd_code;
   logic [1:0]  addr_kind;
   logic        name_empty;
   logic [15:0] dest_port;

   beat_type    step_results[$];
   beat_type    awaited_results[$];

   function automatic void session_reset();
      hs_enable  = 1'b1;
      ph         = PH_VER;
      left_count = 8'h00;
      cmd_code   = 8'h00;
      addr_kind  = AT_IPV4;
      name_empty = 1'b0;
      dest_port  = 16'h0000;
   endfunction

   function automatic void emit(input kind_type k, input logic [7:0] d = 8'h00,
                                input logic [1:0] a = AT_IPV4,
                                input logic [15:0] p = 16'h0000);
      beat_type r;
      r.kind      = k;
      r.data      = d;
      r.addr_type = a;
      r.port      = p;
      r.last      = 1'b0;
      step_results.push_back(r);
   endfunction

   // 05 cc 00 00 00 00 00 00 00
   function automatic void emit_reply(input logic [7:0] code);
      emit(KIND_REPLY, SOCKS_VER);
      emit(KIND_REPLY, code);
      for (int i = 2; i < REPLY_LEN; i++)
         emit(KIND_REPLY, 8'h00);
   endfunction

   function automatic void close_session();
      emit(KIND_CLOSE);
      ph = PH_CLOSED;
   endfunction

   function automatic void accept_methods();
      emit(KIND_REPLY, SOCKS_VER);
      emit(KIND_REPLY, AUTH_NONE);
      ph = PH_RVER;
   endfunction

   function automatic void end_of_request();
      if (cmd_code != CMD_CONNECT) begin
         emit_reply(REP_CMD_BAD);
         close_session();
      end else if (dest_port == 16'h0000 || (addr_kind == AT_DOMAIN && name_empty)) begin
         close_session();
      end else begin
         emit(KIND_OPEN, 8'h00, addr_kind, dest_port);
         ph = PH_WAIT;
      end
   endfunction

   function automatic void parse_client_byte(input logic [7:0] b);
      case (ph)
         PH_VER: ph = (b == SOCKS_VER) ? PH_NMETH : PH_NMETH_BAD;
         PH_NMETH_BAD: begin
            // version judged late: 05 FF then close
            emit(KIND_REPLY, SOCKS_VER);
            emit(KIND_REPLY, AUTH_REJECT);
            close_session();
         end
         PH_NMETH: begin
            if (b == 8'h00) begin
               accept_methods();
            end else begin
               left_count = b;
               ph = PH_METHODS;
            end
         end
         PH_METHODS: begin
            left_count = left_count - 8'd1;
            if (left_count == 8'h00)
               accept_methods();
         end
         PH_RVER: ph = PH_CMD;
         PH_CMD: begin
            cmd_code = b;
            ph = PH_RSV;
         end
         PH_RSV: ph = PH_ATYP;
         PH_ATYP: begin
            case (b)
               ATYP_IPV4: begin
                  addr_kind  = AT_IPV4;
                  left_count = IPV4_LEN;
                  name_empty = 1'b0;
                  ph = PH_ADDR;
               end
               ATYP_DOMAIN: begin
                  addr_kind = AT_DOMAIN;
                  ph = PH_DOMLEN;
               end
               ATYP_IPV6: begin
                  addr_kind  = AT_IPV6;
                  left_count = IPV6_LEN;
                  name_empty = 1'b0;
                  ph = PH_ADDR;
               end
               default: close_session();
            endcase
         end
         PH_DOMLEN: begin
            left_count = b;
            name_empty = (b == 8'h00);
            ph = (b == 8'h00) ? PH_PORT_HI : PH_ADDR;
         end
         PH_ADDR: begin
            emit(KIND_ADDR, b, addr_kind);
            left_count = left_count - 8'd1;
            if (left_count == 8'h00)
               ph = PH_PORT_HI;
         end
         PH_PORT_HI: begin
            dest_port = {b, 8'h00};
            ph = PH_PORT_LO;
         end
         PH_PORT_LO: begin
            dest_port[7:0] = b;
            end_of_request();
         end
         PH_RELAY: emit(KIND_RELAY, b);
         default: ;
      endcase
   endfunction

   function automatic void socks_step(input logic mode, input logic [7:0] b,
                                      input logic ok);
      beat_type tail;
      step_results.delete();
      if (!hs_enable) begin
         if (!mode)
            emit(KIND_RELAY, b);
      end else if (!mode) begin
         parse_client_byte(b);
      end else if (ph == PH_WAIT) begin
         if (ok) begin
            emit_reply(REP_OK);
            ph = PH_RELAY;
         end else begin
            emit_reply(REP_FAIL);
            close_session();
         end
      end
      if (step_results.size() > 0) begin
         tail = step_results.pop_back();
         tail.last = 1'b1;
         step_results.push_back(tail);
      end
      foreach (step_results[i])
         awaited_results.push_back(step_results[i]);
   endfunction

   task automatic check_result();
      beat_type want;
      result_count++;
      if (awaited_results.size() == 0) begin
         fail_count++;
         $display("%0t: expected none, got k%0d d%02h a%0d p%04h l%0d", $time,
                  rsp_mon.kind, rsp_mon.data, rsp_mon.addr_type,
                  rsp_mon.target_port, rsp_mon.last);
      end else begin
         want = awaited_results.pop_front();
         if (rsp_mon.kind !== want.kind || rsp_mon.data !== want.data ||
             rsp_mon.addr_type !== want.addr_type ||
             rsp_mon.target_port !== want.port || rsp_mon.last !== want.last) begin
            fail_count++;
            $display("%0t: expected k%0d d%02h a%0d p%04h l%0d, got k%0d d%02h a%0d p%04h l%0d",
                     $time, want.kind, want.data, want.addr_type, want.port, want.last,
                     rsp_mon.kind, rsp_mon.data, rsp_mon.addr_type,
                     rsp_mon.target_port, rsp_mon.last);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         session_reset();
         awaited_results.delete();
      end else begin
         if (csr_write_enable)
            hs_enable = csr_write_data;
         if (req_mon.valid && req_mon.ready)
            socks_step(req_mon.mode, req_mon.in_byte, req_mon.open_ok);
         if (rsp_mon.valid && rsp_mon.ready)
            check_result();
      end
      pending = awaited_results.size();
   end

endmodule

### tb/sv/socks5_connect_handshake_tb.sv
`timescale 1ns / 1ps

// A close is final until reset, and reset comes only once, so each run
// carries exactly one SOCKS5 session. How that session ends (open ok, bad
// greeting version, bad address type, bad command, zero port, empty domain,
// open failed) is drawn at random, so the seed picks the path. After the
// session, random items run in four idling phases with the handshake enable
// toggled; relayed bytes then make up the bulk of the results.
module socks5_connect_handshake_tb;
   import s5h_pkg::*;

   localparam int LIMIT_CYCLES  = 400000;
   localparam int SETTLE_CYCLES = 24;    // queue plus longest burst, with margin
   localparam int HOLD_CYCLES   = 300;
   localparam int PHASE_ITEMS   = 18;
   localparam int RELAY_TARGET  = 24;    // results wanted from the random part

   typedef enum int {
      END_OPEN_OK,
      END_BAD_VER,
      END_BAD_ATYP,
      END_BAD_CMD,
      END_NO_PORT,
      END_NO_NAME,
      END_OPEN_FAIL
   } session_end_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic csr_write_data;

   int send_idle_pct = 0;   // chance per cycle that the sender idles
   int stall_pct     = 0;   // chance per cycle that the receiver stalls
   int hold_requests = 0;   // bump to ask for one long receiver hold-off

   int fail_count;
   int pending;
   int result_count;

   s5h_req_if req_if ();
   s5h_rsp_if rsp_if ();

   socks5_connect_handshake u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_if           (req_if),
      .rsp_if           (rsp_if)
   );

   s5h_result_check u_check (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_mon          (req_if),
      .rsp_mon          (rsp_if),
      .fail_count       (fail_count),
      .pending          (pending),
      .result_count     (result_count)
   );

   always #5ns clock = ~clock;

   function automatic logic [7:0] any_byte();
      return 8'($urandom_range(255, 0));
   endfunction

   // Offer one item, with random idle cycles ahead of it, and hold it until
   // taken. Valid stays high on return so back-to-back items need no gap.
   task automatic send_item(input logic mode, input logic [7:0] b, input logic ok);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.mode    <= mode;
      req_if.in_byte <= b;
      req_if.open_ok <= ok;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_item(1'b0, b, 1'($urandom_range(1, 0)));
   endtask

   // Stop offering, wait until every expected result is in, then give items
   // that cause no result time to leave the parser.
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_enable(input logic v);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Result side: random stalls, plus a long hold-off on request so the
   // job queue fills and the block pushes back on its input.
   initial begin : rsp_ready_drive
      int hold_left = 0;
      int hold_seen = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99, 0) >= stall_pct);
         end
      end
   end

   initial begin : watchdog
      int cycles = 0;
      while (cycles < LIMIT_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      session_end_type session_end;
      int          pick;
      logic [7:0]  v;
      logic [7:0]  method_count;
      logic [7:0]  atyp;
      logic [7:0]  name_len;
      logic [15:0] port;
      int          addr_bytes;
      int          relay_mark;
      int          extra;

      pick = $urandom_range(11, 0);
      session_end = (pick > 6) ? END_OPEN_OK : session_end_type'(pick);

      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data   <= 1'b0;
      req_if.valid     <= 1'b0;
      req_if.mode      <= 1'b0;
      req_if.in_byte   <= 8'h00;
      req_if.open_ok   <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // ---- directed session, no idling ----
      write_enable(1'b1);
      send_item(1'b1, 8'hFF, 1'b1);           // outcome outside wait: ignored

      // greeting: version, method count, methods
      v = SOCKS_VER;
      if (session_end == END_BAD_VER)
         do v = any_byte(); while (v == SOCKS_VER);
      send_byte(v);
      pick = $urandom_range(15, 0);
      if (pick == 0)
         method_count = 8'd12;
      else if (pick < 4)
         method_count = 8'h00;                 // no methods: answer at once
      else
         method_count = 8'($urandom_range(3, 1));
      send_byte(method_count);
      for (int i = 0; i < method_count; i++)
         send_byte(i == 0 ? 8'h00 : i == 1 ? 8'hFF : any_byte());

      // handshake off mid-session: plain relay, parser frozen
      write_enable(1'b0);
      send_byte(8'h00);
      send_item(1'b1, any_byte(), 1'b1);      // outcome while off: ignored
      send_byte(8'hFF);
      write_enable(1'b1);

      // request: version (unchecked), command, reserved, address type
      send_byte(any_byte());
      v = CMD_CONNECT;
      if (session_end == END_BAD_CMD)
         do v = any_byte(); while (v == CMD_CONNECT);
      send_byte(v);
      send_byte(any_byte());
      if (session_end == END_BAD_ATYP) begin
         do atyp = any_byte();
         while (atyp == ATYP_IPV4 || atyp == ATYP_DOMAIN || atyp == ATYP_IPV6);
      end else if (session_end == END_NO_NAME) begin
         atyp = ATYP_DOMAIN;
      end else begin
         pick = $urandom_range(2, 0);
         atyp = (pick == 0) ? ATYP_IPV4 : (pick == 1) ? ATYP_DOMAIN : ATYP_IPV6;
      end
      send_byte(atyp);

      // address; the domain length byte itself is not forwarded
      if (atyp == ATYP_DOMAIN) begin
         if (session_end == END_NO_NAME)
            name_len = 8'h00;
         else if ($urandom_range(15, 0) == 0)
            name_len = 8'd24;
         else
            name_len = 8'($urandom_range(12, 1));
         send_byte(name_len);
         addr_bytes = name_len;
      end else begin
         addr_bytes = (atyp == ATYP_IPV6) ? IPV6_LEN : IPV4_LEN;
      end
      for (int i = 0; i < addr_bytes; i++)
         send_byte(any_byte());

      // big-endian port
      case ($urandom_range(2, 0))
         0:       port = 16'h0001;
         1:       port = 16'hFFFF;
         default: port = 16'($urandom_range(65535, 1));
      endcase
      if (session_end == END_NO_PORT)
         port = 16'h0000;
      send_byte(port[15:8]);
      send_byte(port[7:0]);

      // bytes while waiting for the outcome are dropped
      send_byte(any_byte());
      case (session_end)
         END_OPEN_OK:   send_item(1'b1, any_byte(), 1'b1);
         END_OPEN_FAIL: send_item(1'b1, any_byte(), 1'b0);
         default:       send_item(1'b1, any_byte(), 1'($urandom_range(1, 0)));
      endcase
      send_item(1'b1, any_byte(), 1'($urandom_range(1, 0)));   // late outcome

      // ---- random items in four idling phases ----
      wait_drained();
      relay_mark = result_count;
      for (int p = 0; p < 4; p++) begin
         case (p)
            0:       write_enable(1'b0);
            1:       write_enable(1'b1);
            default: write_enable(1'($urandom_range(1, 0)));
         endcase
         send_idle_pct = (p == 1) ? 82 : (p == 3) ? 12 : 0;
         stall_pct     = (p == 2) ? 82 : (p == 3) ? 12 : 0;
         if (p == 0)
            hold_requests++;                   // sender keeps going meanwhile
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 2 && i == PHASE_ITEMS / 2)
               wait_drained();                 // sender pause until all is in
            if ($urandom_range(4, 0) == 0)
               send_item(1'b1, any_byte(), 1'($urandom_range(1, 0)));
            else
               send_byte(any_byte());
         end
      end

      // a closed session relays nothing while enabled; top up with relay
      wait_drained();
      extra = RELAY_TARGET - (result_count - relay_mark);
      if (extra > 0) begin
         write_enable(1'b0);
         repeat (extra) send_byte(any_byte());
      end

      wait_drained();
      @(negedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
